// File: rtl/assert_macros.svh
// Assertion helpers for the CSV field parser checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define CFP_ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("cfp assertion failed");

// Clocked assertion that must also hold during reset.
`define CFP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("cfp assertion failed");

`endif

// File: rtl/cfp_pkg.sv
`default_nettype none

package cfp_pkg;

  localparam int unsigned MaxColumnsDefault = 256;

  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChLf      = 8'h0A;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChNeutral = 8'h61;

  localparam logic KindData = 1'b0;
  localparam logic KindEnd  = 1'b1;

  typedef enum logic [2:0] {
    CE_NONE       = 3'd0,
    CE_CELL       = 3'd1,
    CE_ROW        = 3'd2,
    CE_FINAL_ROW  = 3'd3,
    CE_INPUT_END  = 3'd4
  } cell_end_e;

  typedef enum logic [2:0] {
    ERR_OK          = 3'd0,
    ERR_LONE_CR     = 3'd1,
    ERR_QUOTE_MID   = 3'd2,
    ERR_AFTER_QUOTE = 3'd3,
    ERR_EMPTY_LINE  = 3'd4
  } err_e;

  // Per-cell parse state; cleared at every cell end.
  typedef struct packed {
    logic       inside_quotes;
    logic [7:0] prev_byte;
    logic       cell_started;
    logic       cell_has_content;
  } cell_state_t;

  localparam cell_state_t CellStateReset = '{
    inside_quotes:    1'b0,
    prev_byte:        ChNeutral,
    cell_started:     1'b0,
    cell_has_content: 1'b0
  };

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    cell_end_e  cell_end;
    logic [7:0] column_index;
    err_e       error_code;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/cfp_step.sv
`default_nettype none

// Classifies one byte against the current parse state and produces the
// next state together with the result item.
module cfp_step #(
  parameter int unsigned MaxColumns = cfp_pkg::MaxColumnsDefault,
  parameter int unsigned CntW       = $clog2(MaxColumns)
) (
  input  wire logic                 kind_i,
  input  wire logic [7:0]           in_byte_i,
  input  wire cfp_pkg::cell_state_t cell_i,
  input  wire logic [CntW-1:0]      col_cnt_i,
  input  wire cfp_pkg::err_e        err_i,
  output cfp_pkg::cell_state_t      cell_o,
  output logic [CntW-1:0]           col_cnt_o,
  output cfp_pkg::err_e             err_o,
  output cfp_pkg::result_t          result_o
);

  localparam logic [CntW-1:0] ColMax = CntW'(MaxColumns - 1);

  logic [7:0] col_sat;
  logic       row_empty;

  // The reported index saturates at 255 even when the counter is wider.
  if (CntW > 8) begin : g_wide
    assign col_sat = (col_cnt_i > CntW'(255)) ? 8'hFF : col_cnt_i[7:0];
  end else begin : g_narrow
    assign col_sat = 8'(col_cnt_i);
  end

  assign row_empty = !cell_i.cell_has_content && (col_cnt_i == '0);

  always_comb begin
    cell_o    = cell_i;
    col_cnt_o = col_cnt_i;
    err_o     = err_i;
    result_o  = '{
      data_valid:   1'b0,
      data_byte:    8'h00,
      cell_end:     cfp_pkg::CE_NONE,
      column_index: col_sat,
      error_code:   err_i
    };

    if (err_i == cfp_pkg::ERR_OK) begin
      if (kind_i == cfp_pkg::KindEnd) begin
        result_o.cell_end = row_empty ? cfp_pkg::CE_INPUT_END : cfp_pkg::CE_FINAL_ROW;
        cell_o    = cfp_pkg::CellStateReset;
        col_cnt_o = '0;
      end else if (cell_i.inside_quotes) begin
        if (in_byte_i == cfp_pkg::ChQuote) begin
          cell_o.inside_quotes = 1'b0;
        end else begin
          result_o.data_valid     = 1'b1;
          result_o.data_byte      = in_byte_i;
          cell_o.cell_has_content = 1'b1;
        end
        cell_o.prev_byte    = in_byte_i;
        cell_o.cell_started = 1'b1;
      end else if (cell_i.prev_byte == cfp_pkg::ChCr && in_byte_i != cfp_pkg::ChLf) begin
        err_o = cfp_pkg::ERR_LONE_CR;
      end else if (in_byte_i == cfp_pkg::ChQuote) begin
        if (cell_i.prev_byte == cfp_pkg::ChQuote) begin
          // A doubled quote outside quotes is a literal quote and reopens.
          result_o.data_valid     = 1'b1;
          result_o.data_byte      = in_byte_i;
          cell_o.cell_has_content = 1'b1;
          cell_o.inside_quotes    = 1'b1;
          cell_o.prev_byte        = in_byte_i;
          cell_o.cell_started     = 1'b1;
        end else if (cell_i.cell_started) begin
          err_o = cfp_pkg::ERR_QUOTE_MID;
        end else begin
          cell_o.inside_quotes = 1'b1;
          cell_o.prev_byte     = in_byte_i;
          cell_o.cell_started  = 1'b1;
        end
      end else if (in_byte_i == cfp_pkg::ChCr) begin
        cell_o.prev_byte    = in_byte_i;
        cell_o.cell_started = 1'b1;
      end else if (in_byte_i == cfp_pkg::ChLf) begin
        if (row_empty) begin
          err_o = cfp_pkg::ERR_EMPTY_LINE;
        end else begin
          result_o.cell_end = cfp_pkg::CE_ROW;
          cell_o    = cfp_pkg::CellStateReset;
          col_cnt_o = '0;
        end
      end else if (in_byte_i == cfp_pkg::ChComma) begin
        result_o.cell_end = cfp_pkg::CE_CELL;
        cell_o = cfp_pkg::CellStateReset;
        if (col_cnt_i != ColMax) begin
          col_cnt_o = col_cnt_i + CntW'(1);
        end
      end else if (cell_i.prev_byte == cfp_pkg::ChQuote) begin
        err_o = cfp_pkg::ERR_AFTER_QUOTE;
      end else begin
        result_o.data_valid     = 1'b1;
        result_o.data_byte      = in_byte_i;
        cell_o.cell_has_content = 1'b1;
        cell_o.prev_byte        = in_byte_i;
        cell_o.cell_started     = 1'b1;
      end
    end

    result_o.error_code = err_o;
  end

endmodule

`default_nettype wire

// File: rtl/csv_field_parser_top.sv
// A byte accepted into the input register is classified by cfp_step and moves
// into the result register; a stalled sink can hold it in either register.
// Throughput: one byte per cycle unless the sink stalls; parse state is registered.
// Reset: asynchronous, active low; clears all parse state, the column count
// and the sticky error, and empties both register stages.
`default_nettype none

module csv_field_parser_top #(
  parameter int unsigned MAX_COLUMNS = cfp_pkg::MaxColumnsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tuser,   // [0] kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] data_byte, [15:8] column_index,
                                           // [18:16] error_code, [23:19] zero
  output logic [3:0]       m_axis_tuser    // [0] data_valid, [3:1] cell_end
);

  localparam int unsigned CntW = $clog2(MAX_COLUMNS);

  logic                 in_valid_q;
  logic                 kind_q;
  logic [7:0]           byte_q;
  logic                 out_free;
  logic                 advance;

  cfp_pkg::cell_state_t cell_q, cell_d;
  logic [CntW-1:0]      col_cnt_q, col_cnt_d;
  cfp_pkg::err_e        err_q, err_d;
  cfp_pkg::result_t     res_d, res_q;
  logic                 out_valid_q;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q <= s_axis_tuser;
      byte_q <= s_axis_tdata;
    end
  end

  cfp_step #(
    .MaxColumns (MAX_COLUMNS),
    .CntW       (CntW)
  ) u_step (
    .kind_i    (kind_q),
    .in_byte_i (byte_q),
    .cell_i    (cell_q),
    .col_cnt_i (col_cnt_q),
    .err_i     (err_q),
    .cell_o    (cell_d),
    .col_cnt_o (col_cnt_d),
    .err_o     (err_d),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q    <= cfp_pkg::CellStateReset;
      col_cnt_q <= '0;
      err_q     <= cfp_pkg::ERR_OK;
    end else if (advance) begin
      cell_q    <= cell_d;
      col_cnt_q <= col_cnt_d;
      err_q     <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, res_q.error_code, res_q.column_index, res_q.data_byte};
  assign m_axis_tuser  = {res_q.cell_end, res_q.data_valid};

endmodule

`default_nettype wire

// File: rtl/cfp_checker.sv
`default_nettype none
`include "assert_macros.svh"

module cfp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [3:0]  m_axis_tuser
);

  logic       dv;
  logic [2:0] ce;
  logic [7:0] db;
  logic [2:0] ec;

  assign dv = m_axis_tuser[0];
  assign ce = m_axis_tuser[3:1];
  assign db = m_axis_tdata[7:0];
  assign ec = m_axis_tdata[18:16];

  // A result held back by the sink keeps its payload.
  `CFP_ASSERT_RST(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))

  // An accepted byte is followed by a valid output, checked after the input and result register stages.
  `CFP_ASSERT_RST(a_in_to_out, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)

  // Any result carrying an error has neither content nor a cell end.
  `CFP_ASSERT_RST(a_err_quiet, clk_i, rst_ni,
    m_axis_tvalid && ec != cfp_pkg::ERR_OK |-> !dv && ce == cfp_pkg::CE_NONE)

  // A content byte and a cell end never come in the same result.
  `CFP_ASSERT_RST(a_dv_or_end, clk_i, rst_ni,
    m_axis_tvalid && dv |-> ce == cfp_pkg::CE_NONE && ec == cfp_pkg::ERR_OK)

  // Without content the data byte reads as zero.
  `CFP_ASSERT_RST(a_db_zero, clk_i, rst_ni,
    m_axis_tvalid && !dv |-> db == 8'h00)

endmodule

bind csv_field_parser_top cfp_checker u_cfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
